// File: hw/rtl/bgzf_pkg.sv
// Shared definitions for the BGZF block framer: status codes, header
// constants and the result record. No dependencies.
package bgzf_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 65536;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int BSIZE_W  = 16;

    // Status codes reported with each byte
    localparam logic [STATUS_W-1:0] ST_OK     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ID1    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ID2    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_CM     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FLG    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_XLEN   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SI1    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_SI2    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_SLEN   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BSIZE  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_HALTED = 4'd10;

    // Expected header field values
    localparam logic [BYTE_W-1:0]  HDR_ID1  = 8'd31;
    localparam logic [BYTE_W-1:0]  HDR_ID2  = 8'd139;
    localparam logic [BYTE_W-1:0]  HDR_CM   = 8'd8;
    localparam logic [BYTE_W-1:0]  HDR_FLG  = 8'd4;
    localparam logic [15:0]        HDR_XLEN = 16'd6;
    localparam logic [BYTE_W-1:0]  HDR_SI1  = 8'd66;
    localparam logic [BYTE_W-1:0]  HDR_SI2  = 8'd67;
    localparam logic [15:0]        HDR_SLEN = 16'h0002;
    localparam logic [BSIZE_W-1:0] MIN_BSIZE = 16'd26;

    // Byte positions within the header
    localparam int HDR_LEN = 18;
    localparam logic [4:0] POS_ID1    = 5'd0;
    localparam logic [4:0] POS_ID2    = 5'd1;
    localparam logic [4:0] POS_CM     = 5'd2;
    localparam logic [4:0] POS_FLG    = 5'd3;
    localparam logic [4:0] POS_XLEN_L = 5'd10;
    localparam logic [4:0] POS_XLEN_H = 5'd11;
    localparam logic [4:0] POS_SI1    = 5'd12;
    localparam logic [4:0] POS_SI2    = 5'd13;
    localparam logic [4:0] POS_SLEN_L = 5'd14;
    localparam logic [4:0] POS_SLEN_H = 5'd15;
    localparam logic [4:0] POS_BSZ_L  = 5'd16;
    localparam logic [4:0] POS_BSZ_H  = 5'd17;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                out_valid;
        logic                block_first;
        logic                block_last;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: hw/rtl/bgzf_block_framer.sv
// BGZF block framer top level: header checks, block counter and a
// two-entry output buffer. Depends on bgzf_pkg.
//
// Results are registered in the output register or the skid entry.
// Throughput: one byte per cycle while the skid entry is empty; set by
// the combinational header compare and position counter.
// Reset: synchronous, active low; clears position, captured size, held
// low byte, the halted flag and both output entries' valid flags.
module bgzf_block_framer #(
    parameter int MAX_BLOCK_BYTES = bgzf_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bgzf_pkg::BYTE_W-1:0]    s_in_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bgzf_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                           m_out_valid,
    output logic                           m_block_first,
    output logic                           m_block_last,
    output logic [bgzf_pkg::STATUS_W-1:0]  m_status
);
    import bgzf_pkg::*;

    localparam int POS_W = $clog2(MAX_BLOCK_BYTES);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BSIZE_W-1:0] bsize_reg, bsize_next;
    logic [BYTE_W-1:0]  low_reg, low_next;
    logic               halted_reg, halted_next;

    result_t res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept;
    logic [15:0] word;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign word    = {s_in_byte, low_reg};

    // Check the header and advance the block position for one byte
    always_comb begin
        pos_next    = pos_reg;
        bsize_next  = bsize_reg;
        low_next    = low_reg;
        halted_next = halted_reg;
        res         = '0;
        if (halted_reg) begin
            res.status = ST_HALTED;
        end else begin
            res.out_byte    = s_in_byte;
            res.out_valid   = 1'b1;
            res.block_first = (pos_reg == '0);
            res.status      = ST_OK;
            if (32'(pos_reg) < HDR_LEN) begin
                case (pos_reg[4:0])
                    POS_ID1: if (s_in_byte != HDR_ID1) res.status = ST_ID1;
                    POS_ID2: if (s_in_byte != HDR_ID2) res.status = ST_ID2;
                    POS_CM:  if (s_in_byte != HDR_CM)  res.status = ST_CM;
                    POS_FLG: if (s_in_byte != HDR_FLG) res.status = ST_FLG;
                    POS_XLEN_L, POS_SLEN_L, POS_BSZ_L: low_next = s_in_byte;
                    POS_XLEN_H: if (word != HDR_XLEN) res.status = ST_XLEN;
                    POS_SI1: if (s_in_byte != HDR_SI1) res.status = ST_SI1;
                    POS_SI2: if (s_in_byte != HDR_SI2) res.status = ST_SI2;
                    POS_SLEN_H: if (word != HDR_SLEN) res.status = ST_SLEN;
                    POS_BSZ_H: begin
                        bsize_next = word;
                        if (word < MIN_BSIZE ||
                            {1'b0, word} >= 17'(MAX_BLOCK_BYTES)) begin
                            res.status = ST_BSIZE;
                        end
                    end
                    default: ;
                endcase
            end else if (16'(pos_reg) >= bsize_reg) begin
                res.block_last = 1'b1;
            end
            // Halt on the first failed check
            if (res.status != ST_OK) begin
                halted_next    = 1'b1;
                res.block_last = 1'b0;
            end
            pos_next = res.block_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    // Hold framer state; update only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            bsize_reg  <= '0;
            low_reg    <= '0;
            halted_reg <= 1'b0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            bsize_reg  <= bsize_next;
            low_reg    <= low_next;
            halted_reg <= halted_next;
        end
    end

    // Advance the output register and skid entry valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (!accept) begin
                out_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg) begin
            if (accept) out_valid_reg <= 1'b1;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Load result payloads
    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (!out_valid_reg) begin
            if (accept) out_reg <= res;
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_reg.out_byte;
    assign m_out_valid   = out_reg.out_valid;
    assign m_block_first = out_reg.block_first;
    assign m_block_last  = out_reg.block_last;
    assign m_status      = out_reg.status;

endmodule
